// ===== rtl/json_string_field_extractor_core_macros.svh =====
// Assertion macros used by the extractor core.
`ifndef JSON_STRING_FIELD_EXTRACTOR_CORE_MACROS_SVH
`define JSON_STRING_FIELD_EXTRACTOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define JSFX_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define JSFX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/jsfx_pkg.sv =====
package jsfx_pkg;

  localparam int MAX_KEY_BYTES_DEF = 8;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 64;
  localparam int KEY_LEN_W         = 4;
  localparam int BUF_SIZE_W        = 16;
  localparam int KEY_POS_W         = 4;
  localparam int PHASE_W           = 3;

  localparam logic [BUF_SIZE_W-1:0] BUF_SIZE_RST = 16'd256;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE = 2'd2;

  // Parse phases.
  localparam logic [PHASE_W-1:0] PH_OPEN       = 3'd0;
  localparam logic [PHASE_W-1:0] PH_BETWEEN    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_KEY        = 3'd2;
  localparam logic [PHASE_W-1:0] PH_COLON      = 3'd3;
  localparam logic [PHASE_W-1:0] PH_VALUE_OPEN = 3'd4;
  localparam logic [PHASE_W-1:0] PH_VALUE      = 3'd5;
  localparam logic [PHASE_W-1:0] PH_DONE       = 3'd6;

  // Result kinds.
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_object;
  } in_word_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] value_char;
    logic       is_last;
  } out_word_t;

  typedef struct packed {
    logic [KEY_LEN_W-1:0]  key_length;
    logic [BUF_SIZE_W-1:0] buffer_size;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0]    phase;
    logic                  escape_pending;
    logic [KEY_POS_W-1:0]  key_position;
    logic                  key_still_matches;
    logic                  field_is_wanted;
    logic [BUF_SIZE_W-1:0] chars_emitted;
    logic                  answer_given;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '{
    phase:             PH_OPEN,
    escape_pending:    1'b0,
    key_position:      '0,
    key_still_matches: 1'b1,
    field_is_wanted:   1'b0,
    chars_emitted:     '0,
    answer_given:      1'b0
  };

endpackage

// ===== rtl/json_string_field_extractor_core.sv =====
// A word's result passes from the input register into the result register through combinational step logic.
// Throughput: one word per cycle while the output is not stalled; the byte-wise parse state takes one step per word.
// Output stalls back up through the input register, one word deep on each side.
// Reset (rst_n low at a clock edge) empties both registers, restarts the parser
// at the opening brace and sets key_bytes=0, key_length=0, buffer_size=256.
module json_string_field_extractor_core #(
  parameter int MAX_KEY_BYTES = jsfx_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  jsfx_pkg::in_word_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output jsfx_pkg::out_word_t              out_data,
  input  logic                             cfg_we,
  input  logic [jsfx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jsfx_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import jsfx_pkg::*;

  `include "json_string_field_extractor_core_macros.svh"

  // Configuration registers.
  logic [MAX_KEY_BYTES*8-1:0] key_bytes;
  cfg_t                       cfg;

  jsfx_cfg #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .key_bytes_o(key_bytes),
    .cfg_o      (cfg)
  );

  // Input register. A held word is processed once the result register can
  // take whatever it produces, so the input register holds its word while an
  // earlier result waits to be taken.
  logic         in_valid_r;
  in_word_t     in_word_r;
  logic         advance;

  // Parser state and the step logic that updates it.
  parse_state_t st_r;
  parse_state_t st_nxt;
  logic         has_result;
  out_word_t    result;

  // Result register.
  logic         out_valid_r;
  out_word_t    out_word_r;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r <= in_data;
    end
  end

  jsfx_step #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) u_step (
    .st_i       (st_r),
    .word_i     (in_word_r),
    .cfg_i      (cfg),
    .key_bytes_i(key_bytes),
    .st_nxt     (st_nxt),
    .has_result (has_result),
    .result     (result)
  );

  // The parser state moves only when the held word is consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_CLEAR;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Words that produce no result simply leave the result register alone.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // Once the answer is out, nothing but the end flag may produce a result.
  `JSFX_ASSERT_SAME(a_quiet_after_answer, advance && st_r.answer_given && !in_word_r.end_of_object, !has_result, "result after answer was given")

  // A final result leaves the parser either done or waiting for a new object.
  `JSFX_ASSERT_NEXT(a_final_sets_done, advance && has_result && result.result_kind != KIND_CHAR, st_r.answer_given || st_r.phase == PH_OPEN, "final result without done state")

  // Value characters come only from the wanted field's value.
  `JSFX_ASSERT_SAME(a_char_only_in_value, advance && has_result && result.result_kind == KIND_CHAR, st_r.field_is_wanted && st_r.phase == PH_VALUE, "character outside the wanted value")

endmodule

// ===== rtl/jsfx_cfg.sv =====
module jsfx_cfg #(
  parameter int MAX_KEY_BYTES = jsfx_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [jsfx_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [jsfx_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic [MAX_KEY_BYTES*8-1:0]        key_bytes_o,
  output jsfx_pkg::cfg_t                    cfg_o
);
  import jsfx_pkg::*;

  logic [MAX_KEY_BYTES*8-1:0] key_bytes_r;
  cfg_t                       cfg_r;

  // Only the key bytes that can ever be compared are stored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_bytes_r       <= '0;
      cfg_r.key_length  <= '0;
      cfg_r.buffer_size <= BUF_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_BYTES:   key_bytes_r       <= cfg_wdata[MAX_KEY_BYTES*8-1:0];
        CFG_KEY_LENGTH:  cfg_r.key_length  <= cfg_wdata[KEY_LEN_W-1:0];
        CFG_BUFFER_SIZE: cfg_r.buffer_size <= cfg_wdata[BUF_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign key_bytes_o = key_bytes_r;
  assign cfg_o       = cfg_r;

endmodule

// ===== rtl/jsfx_step.sv =====
module jsfx_step #(
  parameter int MAX_KEY_BYTES = jsfx_pkg::MAX_KEY_BYTES_DEF
) (
  input  jsfx_pkg::parse_state_t     st_i,
  input  jsfx_pkg::in_word_t         word_i,
  input  jsfx_pkg::cfg_t             cfg_i,
  input  logic [MAX_KEY_BYTES*8-1:0] key_bytes_i,
  output jsfx_pkg::parse_state_t     st_nxt,
  output logic                       has_result,
  output jsfx_pkg::out_word_t        result
);
  import jsfx_pkg::*;

  localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [KEY_POS_W-1:0] KEY_POS_MAX = KEY_POS_W'(MAX_KEY_BYTES);

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
           (c == 8'h0C) || (c == 8'h0D);
  endfunction

  logic [7:0]            c;
  logic [KIDX_W-1:0]     key_idx;
  logic [7:0]            want_byte;
  logic                  key_hit;
  logic                  esc_known;
  logic [7:0]            esc_char;
  logic [7:0]            emit_val;
  logic                  do_emit;
  logic                  buf_full;
  logic                  fail_now;
  logic                  ok_now;

  assign c         = word_i.data_byte;
  assign key_idx   = st_i.key_position[KIDX_W-1:0];
  assign want_byte = key_bytes_i[8*key_idx +: 8];
  assign key_hit   = (st_i.key_position < KEY_POS_MAX) &&
                     (st_i.key_position < cfg_i.key_length) && (want_byte == c);
  assign buf_full  = ({1'b0, st_i.chars_emitted} + 17'd1) >= {1'b0, cfg_i.buffer_size};

  always_comb begin
    esc_known = 1'b1;
    esc_char  = c;
    unique case (c)
      8'h22:   esc_char = 8'h22;
      8'h5C:   esc_char = 8'h5C;
      8'h2F:   esc_char = 8'h2F;
      8'h6E:   esc_char = 8'h0A;
      8'h72:   esc_char = 8'h0D;
      8'h74:   esc_char = 8'h09;
      8'h62:   esc_char = 8'h08;
      8'h66:   esc_char = 8'h0C;
      default: esc_known = 1'b0;
    endcase
  end

  always_comb begin
    st_nxt   = st_i;
    do_emit  = 1'b0;
    emit_val = c;
    fail_now = 1'b0;
    ok_now   = 1'b0;

    if (word_i.end_of_object) begin
      st_nxt   = STATE_CLEAR;
      fail_now = !(st_i.answer_given || (st_i.phase == PH_DONE));
    end else begin
      unique case (st_i.phase)
        PH_OPEN: begin
          if (cfg_i.buffer_size == '0) fail_now = 1'b1;
          else st_nxt.phase = PH_BETWEEN;
        end
        PH_BETWEEN: begin
          if (!(is_ws(c) || c == 8'h2C)) begin
            if (c != 8'h22) begin
              fail_now = 1'b1;
            end else begin
              st_nxt.phase             = PH_KEY;
              st_nxt.escape_pending    = 1'b0;
              st_nxt.key_position      = '0;
              st_nxt.key_still_matches = 1'b1;
            end
          end
        end
        PH_KEY: begin
          if (!st_i.escape_pending && c == 8'h22) begin
            st_nxt.phase = PH_COLON;
          end else begin
            // A backslash and the byte after it are both compared raw.
            st_nxt.escape_pending = !st_i.escape_pending && (c == 8'h5C);
            if (!key_hit) st_nxt.key_still_matches = 1'b0;
            if (st_i.key_position < KEY_POS_MAX + KEY_POS_W'(1)) begin
              st_nxt.key_position = st_i.key_position + KEY_POS_W'(1);
            end
          end
        end
        PH_COLON: begin
          if (!is_ws(c)) begin
            if (c != 8'h3A) fail_now = 1'b1;
            else st_nxt.phase = PH_VALUE_OPEN;
          end
        end
        PH_VALUE_OPEN: begin
          if (!is_ws(c)) begin
            if (c != 8'h22) begin
              fail_now = 1'b1;
            end else begin
              st_nxt.phase           = PH_VALUE;
              st_nxt.escape_pending  = 1'b0;
              st_nxt.chars_emitted   = '0;
              st_nxt.field_is_wanted = st_i.key_still_matches &&
                                       (st_i.key_position == cfg_i.key_length);
            end
          end
        end
        PH_VALUE: begin
          if (st_i.escape_pending) begin
            st_nxt.escape_pending = 1'b0;
            if (st_i.field_is_wanted) begin
              if (!esc_known) fail_now = 1'b1;
              else begin
                do_emit  = 1'b1;
                emit_val = esc_char;
              end
            end
          end else if (c == 8'h5C) begin
            st_nxt.escape_pending = 1'b1;
          end else if (c == 8'h22) begin
            if (st_i.field_is_wanted) ok_now = 1'b1;
            else st_nxt.phase = PH_BETWEEN;
          end else if (st_i.field_is_wanted) begin
            do_emit = 1'b1;
          end
        end
        default: ;
      endcase

      // A character that would not fit in the buffer turns into a failure.
      if (do_emit && buf_full) begin
        do_emit  = 1'b0;
        fail_now = 1'b1;
      end
      if (do_emit) st_nxt.chars_emitted = st_i.chars_emitted + BUF_SIZE_W'(1);
      if (fail_now || ok_now) begin
        st_nxt.phase        = PH_DONE;
        st_nxt.answer_given = 1'b1;
      end
    end
  end

  always_comb begin
    has_result = do_emit || fail_now || ok_now;
    result     = '0;
    if (do_emit) begin
      result.result_kind = KIND_CHAR;
      result.value_char  = emit_val;
    end else if (ok_now) begin
      result.result_kind = KIND_OK;
      result.is_last     = 1'b1;
    end else if (fail_now) begin
      result.result_kind = KIND_FAIL;
      result.is_last     = 1'b1;
    end
  end

endmodule
